@@ rtl/utc_pkg.sv @@
// shared constants, types and fixed-point helpers for the unicycle tracking controller
// no dependencies
package utc_pkg;

  localparam int unsigned GAIN_W   = 15;
  localparam int unsigned TRIG_LAT = 26;

  localparam logic signed [16:0] PI_Q12      = 17'sd12868;
  localparam logic signed [16:0] HALF_PI_Q12 = 17'sd6434;
  localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;

  localparam logic [GAIN_W-1:0] GAIN_ALONG_RST   = 15'd7782;
  localparam logic [GAIN_W-1:0] GAIN_LATERAL_RST = 15'd8602;
  localparam logic [GAIN_W-1:0] GAIN_HEADING_RST = 15'd7782;

  typedef enum logic [1:0] {
    REG_GAIN_ALONG   = 2'd0,
    REG_GAIN_LATERAL = 2'd1,
    REG_GAIN_HEADING = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic                clip;
    logic signed [15:0]  val;
  } sat_t;

  function automatic logic signed [16:0] wrap_angle(input logic signed [16:0] a);
    logic signed [16:0] w;
    w = a;
    for (int i = 0; i < 2; i++) begin
      if (w > PI_Q12) begin
        w = w - TWO_PI_Q12;
      end else if (w < -PI_Q12) begin
        w = w + TWO_PI_Q12;
      end
    end
    return w;
  endfunction

  // round half away from zero, drop n fraction bits
  function automatic longint rnd(input longint v, input int unsigned n);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) <<< (n - 1))) >>> n;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic signed [15:0] clamp14(input longint v);
    if (v > 16384) begin
      return 16'sd16384;
    end
    if (v < -16384) begin
      return -16'sd16384;
    end
    return 16'(v);
  endfunction

  function automatic sat_t sat16(input longint v);
    sat_t s;
    s.clip = 1'b0;
    s.val  = 16'(v);
    if (v > 32767) begin
      s.clip = 1'b1;
      s.val  = 16'sh7fff;
    end else if (v < -32768) begin
      s.clip = 1'b1;
      s.val  = 16'sh8000;
    end
    return s;
  endfunction

endpackage

@@ rtl/unicycle_tracking_controller.sv @@
// Unicycle trajectory tracking controller: pose error in the robot frame, heading
// wrap and nonlinear speed and turn commands. Takes one transaction per clock while
// the output buffer has room; results pass through the 26-stage sine/cosine/sinc unit
// (series evaluation plus a 15-stage restoring divider for sinc) and six stages of
// multiply, round and saturate. A two-entry output buffer lets input continue while
// a result waits; input stops only when both entries are full. The user must write
// gains through cfg_wr/cfg_addr/cfg_wdata while no transaction is in flight (not enforced).
// depends on utc_pkg and utc_trig
module unicycle_tracking_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // ref_x, ref_y, ref_heading, ref_speed, ref_turn_rate, meas_x, meas_y, meas_heading
  input  logic [127:0]                        s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // speed_cmd, turn_cmd
  output logic [31:0]                         m_tdata,
  // saturated
  output logic                                m_tuser,
  input  logic                                cfg_wr,
  input  logic [1:0]                          cfg_addr,
  input  logic [utc_pkg::GAIN_W-1:0]          cfg_wdata
);
  import utc_pkg::*;

  localparam int unsigned NSTG = TRIG_LAT + 7;

  typedef struct packed {
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [14:0] eth;
    logic signed [13:0] vr;
    logic signed [13:0] wr;
  } dly_t;

  logic [GAIN_W-1:0]  gain_along, gain_lateral, gain_heading;
  logic               en;
  logic               vld [0:NSTG-1];

  logic signed [16:0] s0_rx, s0_ry, s0_mx, s0_my;
  logic signed [14:0] s0_rh, s0_mh;
  logic signed [13:0] s0_vr, s0_wr;
  logic signed [16:0] eth0;
  dly_t               dl [0:TRIG_LAT-1];
  logic signed [15:0] sm_a, cm_a, se_b, ce_b, sce_b;

  logic signed [33:0] p1_cdx, p1_sdy, p1_cdy, p1_sdx;
  logic signed [29:0] p1_vce, p1_kv;
  logic signed [30:0] p1_heth;
  logic signed [13:0] p1_wr;
  logic signed [15:0] p1_sce;

  logic signed [19:0] p2_ex, p2_ey;
  logic signed [17:0] p2_kv;
  logic signed [29:0] p2_vce;
  logic signed [30:0] p2_heth;
  logic signed [13:0] p2_wr;
  logic signed [15:0] p2_sce;

  logic signed [35:0] p3_gex;
  logic signed [37:0] p3_kvey;
  logic signed [29:0] p3_vce;
  logic signed [30:0] p3_heth;
  logic signed [13:0] p3_wr;
  logic signed [15:0] p3_sce;

  sat_t               p4_spd;
  logic signed [53:0] p4_latp;
  logic signed [30:0] p4_heth;
  logic signed [13:0] p4_wr;

  sat_t               p5_spd;
  logic signed [38:0] p5_trn;

  sat_t               p6_spd, p6_trn;

  logic signed [15:0] out_speed, out_turn, skid_speed, skid_turn;
  logic               out_clip, skid_clip, skid_v;
  logic               push;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_along   <= GAIN_ALONG_RST;
      gain_lateral <= GAIN_LATERAL_RST;
      gain_heading <= GAIN_HEADING_RST;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        REG_GAIN_ALONG:   gain_along   <= cfg_wdata;
        REG_GAIN_LATERAL: gain_lateral <= cfg_wdata;
        REG_GAIN_HEADING: gain_heading <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !skid_v;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTG; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < NSTG; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_rx <= s_tdata[16:0];
      s0_ry <= s_tdata[33:17];
      s0_rh <= s_tdata[48:34];
      s0_vr <= s_tdata[62:49];
      s0_wr <= s_tdata[76:63];
      s0_mx <= s_tdata[93:77];
      s0_my <= s_tdata[110:94];
      s0_mh <= s_tdata[125:111];
    end
  end

  assign eth0 = wrap_angle(17'(s0_rh) - 17'(s0_mh));

  utc_trig u_trig_meas (
    .clk    (clk),
    .en     (en),
    .ang    (17'(s0_mh)),
    .sine   (sm_a),
    .cosine (cm_a),
    .sinc   ()
  );

  utc_trig u_trig_err (
    .clk    (clk),
    .en     (en),
    .ang    (eth0),
    .sine   (se_b),
    .cosine (ce_b),
    .sinc   (sce_b)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= '{dx: 18'(s0_rx) - 18'(s0_mx), dy: 18'(s0_ry) - 18'(s0_my),
                 eth: eth0[14:0], vr: s0_vr, wr: s0_wr};
      for (int i = 1; i < TRIG_LAT; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_cdx  <= cm_a * dl[TRIG_LAT-1].dx;
      p1_sdy  <= sm_a * dl[TRIG_LAT-1].dy;
      p1_cdy  <= cm_a * dl[TRIG_LAT-1].dy;
      p1_sdx  <= sm_a * dl[TRIG_LAT-1].dx;
      p1_vce  <= dl[TRIG_LAT-1].vr * ce_b;
      p1_kv   <= $signed({1'b0, gain_lateral}) * dl[TRIG_LAT-1].vr;
      p1_heth <= $signed({1'b0, gain_heading}) * dl[TRIG_LAT-1].eth;
      p1_wr   <= dl[TRIG_LAT-1].wr;
      p1_sce  <= sce_b;

      p2_ex   <= 20'(rnd(longint'(p1_cdx) + longint'(p1_sdy), 14));
      p2_ey   <= 20'(rnd(longint'(p1_cdy) - longint'(p1_sdx), 14));
      p2_kv   <= 18'(rnd(longint'(p1_kv), 12));
      p2_vce  <= p1_vce;
      p2_heth <= p1_heth;
      p2_wr   <= p1_wr;
      p2_sce  <= p1_sce;

      p3_gex  <= $signed({1'b0, gain_along}) * p2_ex;
      p3_kvey <= p2_kv * p2_ey;
      p3_vce  <= p2_vce;
      p3_heth <= p2_heth;
      p3_wr   <= p2_wr;
      p3_sce  <= p2_sce;

      p4_spd  <= sat16(rnd(longint'(p3_vce) + longint'(p3_gex) * 4, 14));
      p4_latp <= p3_kvey * p3_sce;
      p4_heth <= p3_heth;
      p4_wr   <= p3_wr;

      p5_spd  <= p4_spd;
      p5_trn  <= 39'(longint'(p4_wr) * 4096 + rnd(longint'(p4_latp), 14)
                     + longint'(p4_heth));

      p6_spd  <= p5_spd;
      p6_trn  <= sat16(rnd(longint'(p5_trn), 12));
    end
  end

  // output register plus skid entry
  assign push = en && vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_v) begin
        m_tvalid <= 1'b1;
        skid_v   <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_v) begin
        out_speed <= skid_speed;
        out_turn  <= skid_turn;
        out_clip  <= skid_clip;
      end else begin
        out_speed <= p6_spd.val;
        out_turn  <= p6_trn.val;
        out_clip  <= p6_spd.clip | p6_trn.clip;
      end
    end else if (push) begin
      skid_speed <= p6_spd.val;
      skid_turn  <= p6_trn.val;
      skid_clip  <= p6_spd.clip | p6_trn.clip;
    end
  end

  assign m_tdata = {out_turn, out_speed};
  assign m_tuser = out_clip;

endmodule

@@ rtl/utc_trig.sv @@
// pipelined sine, cosine and sinc of a q4.12 angle, results q1.14
// series evaluation in q.28 then a restoring divider for the folded sinc; uses utc_pkg
module utc_trig (
  input  logic               clk,
  input  logic               en,
  input  logic signed [16:0] ang,
  output logic signed [15:0] sine,
  output logic signed [15:0] cosine,
  output logic signed [15:0] sinc
);
  import utc_pkg::*;

  localparam logic [28:0] ONE_Q28 = 29'd1 << 28;
  localparam logic [30:0] RC72 = 31'(((64'd1 << 37) + 64'd71) / 64'd72);
  localparam logic [30:0] RC42 = 31'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [30:0] RC20 = 31'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam logic [30:0] RC6  = 31'(((64'd1 << 33) + 64'd5) / 64'd6);
  localparam logic [30:0] RC90 = 31'(((64'd1 << 37) + 64'd89) / 64'd90);
  localparam logic [30:0] RC56 = 31'(((64'd1 << 36) + 64'd55) / 64'd56);
  localparam logic [30:0] RC30 = 31'(((64'd1 << 35) + 64'd29) / 64'd30);
  localparam logic [30:0] RC12 = 31'(((64'd1 << 34) + 64'd11) / 64'd12);
  localparam int unsigned DIV_STG = 15;

  typedef struct packed {
    logic [28:0] xm;
    logic        xsign;
    logic        fold;
    logic [13:0] amag;
  } carry_t;

  typedef struct packed {
    logic [28:0]        rem;
    logic [14:0]        q;
    logic [15:0]        d;
    logic signed [15:0] sine;
    logic signed [15:0] cosine;
    logic signed [15:0] sinc_nf;
    logic               fold;
  } div_t;

  function automatic logic [29:0] mulq(input logic [29:0] a, input logic [28:0] b);
    logic [58:0] p;
    p = a * b;
    return 30'(p >> 28);
  endfunction

  // floor(n / d) for n below 2^30 through a reciprocal constant
  function automatic logic [28:0] divc(input logic [29:0] n, input logic [30:0] m,
                                       input int unsigned s);
    logic [60:0] p;
    p = n * m;
    return 29'(p >> s);
  endfunction

  logic signed [16:0] a0, r0;
  logic [16:0]        rmag0, amag0;
  logic               fold0;
  carry_t             cr [0:9];
  logic [29:0]        x2s [1:8];
  logic [28:0]        ta2, ua2, ta4, ua4, ta6, ua6, ta8, ua8, t4_9, s28m9;
  logic [29:0]        mt3, mu3, mt5, mu5, mt7, mu7, mu9;
  longint             uval, sval;
  div_t               dv_in;
  div_t               dv [0:DIV_STG-1];
  div_t               dv_next [0:DIV_STG-1];

  always_comb begin
    a0    = wrap_angle(ang);
    fold0 = 1'b0;
    r0    = a0;
    if (a0 > HALF_PI_Q12) begin
      r0    = PI_Q12 - a0;
      fold0 = 1'b1;
    end else if (a0 < -HALF_PI_Q12) begin
      r0    = -PI_Q12 - a0;
      fold0 = 1'b1;
    end
    rmag0 = r0[16] ? 17'(-r0) : 17'(r0);
    amag0 = a0[16] ? 17'(-a0) : 17'(a0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr[0] <= '{xm: {rmag0[12:0], 16'b0}, xsign: r0[16], fold: fold0, amag: amag0[13:0]};
      for (int k = 1; k < 10; k++) begin
        cr[k] <= cr[k-1];
      end
      x2s[1] <= mulq(30'(cr[0].xm), cr[0].xm);
      for (int k = 2; k < 9; k++) begin
        x2s[k] <= x2s[k-1];
      end
      ta2   <= ONE_Q28 - divc(x2s[1], RC72, 37);
      ua2   <= ONE_Q28 - divc(x2s[1], RC90, 37);
      mt3   <= mulq(x2s[2], ta2);
      mu3   <= mulq(x2s[2], ua2);
      ta4   <= ONE_Q28 - divc(mt3, RC42, 36);
      ua4   <= ONE_Q28 - divc(mu3, RC56, 36);
      mt5   <= mulq(x2s[4], ta4);
      mu5   <= mulq(x2s[4], ua4);
      ta6   <= ONE_Q28 - divc(mt5, RC20, 35);
      ua6   <= ONE_Q28 - divc(mu5, RC30, 35);
      mt7   <= mulq(x2s[6], ta6);
      mu7   <= mulq(x2s[6], ua6);
      ta8   <= ONE_Q28 - divc(mt7, RC6, 33);
      ua8   <= ONE_Q28 - divc(mu7, RC12, 34);
      s28m9 <= 29'(mulq(30'(cr[8].xm), ta8));
      mu9   <= mulq(x2s[8], ua8);
      t4_9  <= ta8;
    end
  end

  always_comb begin
    uval = longint'(ONE_Q28) - longint'(mu9 >> 1);
    if (cr[9].fold) begin
      uval = -uval;
    end
    sval = cr[9].xsign ? -longint'(s28m9) : longint'(s28m9);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_in.rem     <= s28m9;
      dv_in.q       <= '0;
      dv_in.d       <= {cr[9].amag, 2'b00};
      dv_in.sine    <= clamp14(rnd(sval, 14));
      dv_in.cosine  <= clamp14(rnd(uval, 14));
      dv_in.sinc_nf <= clamp14(rnd(longint'(t4_9), 14));
      dv_in.fold    <= cr[9].fold;
    end
  end

  // one quotient bit per stage, msb first
  always_comb begin
    div_t        src;
    logic [30:0] dsh;
    for (int g = 0; g < DIV_STG; g++) begin
      src = (g == 0) ? dv_in : dv[g-1];
      dsh = 31'(src.d) << (DIV_STG - 1 - g);
      dv_next[g] = src;
      if ({2'b00, src.rem} >= dsh) begin
        dv_next[g].rem = 29'({2'b00, src.rem} - dsh);
        dv_next[g].q[DIV_STG-1-g] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < DIV_STG; g++) begin
        dv[g] <= dv_next[g];
      end
    end
  end

  assign sine   = dv[DIV_STG-1].sine;
  assign cosine = dv[DIV_STG-1].cosine;
  assign sinc   = !dv[DIV_STG-1].fold ? dv[DIV_STG-1].sinc_nf :
                  (dv[DIV_STG-1].q > 15'd16384) ? 16'sd16384 :
                  $signed({1'b0, dv[DIV_STG-1].q});

endmodule
